/* rtl/core/mstx_pkg.sv */
// shared types and constants for the manchester stuffed frame transmitter
package mstx_pkg;

  // line cell kinds as reported on the output word
  typedef enum logic [2:0] {
    KIND_PREAMBLE = 3'd0,
    KIND_FLAG     = 3'd1,
    KIND_PAYLOAD  = 3'd2,
    KIND_STUFF    = 3'd3,
    KIND_CHECK    = 3'd4
  } cell_kind_t;

  localparam logic [7:0]  FlagByte  = 8'h7e;
  localparam logic [15:0] CrcPoly   = 16'h1021;
  localparam logic [15:0] SeedReset = 16'hffff;
  localparam logic [2:0]  StuffRun  = 3'd5;

  // counter width covers the 16 check bits plus a sentinel
  localparam int CntW = 5;
  localparam logic [CntW-1:0] PreLastCnt   = CntW'(15);
  localparam logic [CntW-1:0] FlagLastCnt  = CntW'(7);
  localparam logic [CntW-1:0] DataLastCnt  = CntW'(7);
  localparam logic [CntW-1:0] DataDoneCnt  = CntW'(8);
  localparam logic [CntW-1:0] CheckLastCnt = CntW'(15);
  localparam logic [CntW-1:0] CheckDoneCnt = CntW'(16);

  // controller to datapath commands
  typedef struct packed {
    logic       load;        // capture a new payload byte
    logic       start;       // open a frame: reload crc, clear ones run
    logic       emit;        // write one cell into the output register
    cell_kind_t kind;
    logic       ctl_bit;     // cell value for preamble and flag cells
    logic       shift_data;  // payload bit sent: shift byte, update crc
    logic       shift_check; // check bit sent: shift crc
    logic       close;       // frame closed: clear ones run
    logic       run_end;
    logic       frame_end;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
    logic stuff_due;
    logic ones_four;
    logic data_one;
    logic check_one;
  } dp_status_t;

endpackage

/* rtl/core/mstx_byte_if.sv */
// byte input channel
interface mstx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* rtl/core/mstx_cell_if.sv */
// bit cell output channel
interface mstx_cell_if;
  logic       valid;
  logic       ready;
  logic       first_half_high;
  logic       second_half_high;
  logic [2:0] cell_kind;
  logic       run_end;
  logic       frame_end;

  modport source (output valid, output first_half_high, output second_half_high,
                  output cell_kind, output run_end, output frame_end, input ready);
  modport sink   (input valid, input first_half_high, input second_half_high,
                  input cell_kind, input run_end, input frame_end, output ready);
endinterface

/* rtl/core/mstx_dp.sv */
// datapath: byte shifter, bitwise crc, stuffing run counter, output register
module mstx_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  mstx_pkg::dp_cmd_t    cmd,
  output mstx_pkg::dp_status_t status,
  input  logic [7:0]           data_byte,
  input  logic                 seed_we,
  input  logic [15:0]          seed_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 first_half_high,
  output logic                 second_half_high,
  output logic [2:0]           cell_kind,
  output logic                 run_end,
  output logic                 frame_end
);

  logic [15:0] seed;
  logic [15:0] crc;
  logic [15:0] crc_next;
  logic [7:0]  sh;
  logic [2:0]  ones_run;
  logic        cell_bit;
  logic        fb;

  // value of the cell being emitted
  always_comb begin
    case (cmd.kind)
      mstx_pkg::KIND_PAYLOAD: cell_bit = sh[7];
      mstx_pkg::KIND_CHECK:   cell_bit = crc[15];
      mstx_pkg::KIND_STUFF:   cell_bit = 1'b0;
      default:                cell_bit = cmd.ctl_bit;
    endcase
  end

  // one step of the msb-first crc per payload bit
  assign fb       = crc[15] ^ sh[7];
  assign crc_next = {crc[14:0], 1'b0} ^ (fb ? mstx_pkg::CrcPoly : 16'h0000);

  // seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= mstx_pkg::SeedReset;
    end else if (seed_we) begin
      seed <= seed_data;
    end
  end

  // byte shifter and crc
  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= mstx_pkg::SeedReset;
    end else begin
      if (cmd.load) begin
        sh <= data_byte;
      end else if (cmd.shift_data) begin
        sh <= {sh[6:0], 1'b0};
      end
      if (cmd.start) begin
        crc <= seed;
      end else if (cmd.shift_data) begin
        crc <= crc_next;
      end else if (cmd.shift_check) begin
        crc <= {crc[14:0], 1'b0};
      end
    end
  end

  // consecutive ones count for stuffing
  always_ff @(posedge clk) begin
    if (rst) begin
      ones_run <= 3'd0;
    end else if (cmd.start || cmd.close) begin
      ones_run <= 3'd0;
    end else if (cmd.emit && cmd.kind == mstx_pkg::KIND_STUFF) begin
      ones_run <= 3'd0;
    end else if (cmd.shift_data || cmd.shift_check) begin
      ones_run <= cell_bit ? ones_run + 3'd1 : 3'd0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid        <= 1'b1;
      first_half_high  <= ~cell_bit;
      second_half_high <= cell_bit;
      cell_kind        <= cmd.kind;
      run_end          <= cmd.run_end;
      frame_end        <= cmd.frame_end;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // status back to the controller
  assign status.out_free  = ~out_valid | out_ready;
  assign status.stuff_due = (ones_run == mstx_pkg::StuffRun);
  assign status.ones_four = (ones_run == mstx_pkg::StuffRun - 3'd1);
  assign status.data_one  = sh[7];
  assign status.check_one = crc[15];

endmodule

/* rtl/core/mstx_ctrl.sv */
// controller: frame phase sequencing and cell counting
module mstx_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 last_byte,
  input  mstx_pkg::dp_status_t status,
  output mstx_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_FLAG_OPEN,
    ST_DATA,
    ST_CHECK,
    ST_FLAG_CLOSE
  } state_t;

  state_t                      state;
  logic [mstx_pkg::CntW-1:0]   cnt;
  logic                        in_frame;
  logic                        last;
  logic                        done;

  assign in_ready = (state == ST_IDLE);

  // command decode
  always_comb begin
    cmd  = '0;
    done = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd.load  = in_valid;
        cmd.start = in_valid & ~in_frame;
      end
      ST_PRE: begin
        cmd.emit    = status.out_free;
        cmd.kind    = mstx_pkg::KIND_PREAMBLE;
        cmd.ctl_bit = cnt[0];
        done        = (cnt == mstx_pkg::PreLastCnt);
      end
      ST_FLAG_OPEN, ST_FLAG_CLOSE: begin
        cmd.emit    = status.out_free;
        cmd.kind    = mstx_pkg::KIND_FLAG;
        cmd.ctl_bit = mstx_pkg::FlagByte[~cnt[2:0]];
        done        = (cnt == mstx_pkg::FlagLastCnt);
        if (state == ST_FLAG_CLOSE) begin
          cmd.run_end   = done;
          cmd.frame_end = done;
          cmd.close     = done & status.out_free;
        end
      end
      ST_DATA: begin
        cmd.emit = status.out_free;
        if (status.stuff_due) begin
          cmd.kind = mstx_pkg::KIND_STUFF;
          done     = (cnt == mstx_pkg::DataDoneCnt);
        end else begin
          cmd.kind       = mstx_pkg::KIND_PAYLOAD;
          cmd.shift_data = status.out_free;
          done           = (cnt == mstx_pkg::DataLastCnt) &
                           ~(status.data_one & status.ones_four);
        end
        cmd.run_end = done & ~last;
      end
      ST_CHECK: begin
        cmd.emit = status.out_free;
        if (status.stuff_due) begin
          cmd.kind = mstx_pkg::KIND_STUFF;
          done     = (cnt == mstx_pkg::CheckDoneCnt);
        end else begin
          cmd.kind        = mstx_pkg::KIND_CHECK;
          cmd.shift_check = status.out_free;
          done            = (cnt == mstx_pkg::CheckLastCnt) &
                            ~(status.check_one & status.ones_four);
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // state, counter and frame tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      in_frame <= 1'b0;
      last     <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            last     <= last_byte;
            cnt      <= '0;
            in_frame <= 1'b1;
            state    <= in_frame ? ST_DATA : ST_PRE;
          end
        end
        ST_PRE, ST_FLAG_OPEN: begin
          if (status.out_free) begin
            if (done) begin
              cnt   <= '0;
              state <= (state == ST_PRE) ? ST_FLAG_OPEN : ST_DATA;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        ST_DATA, ST_CHECK: begin
          if (status.out_free) begin
            if (done) begin
              cnt <= '0;
              if (state == ST_CHECK) begin
                state <= ST_FLAG_CLOSE;
              end else begin
                state <= last ? ST_CHECK : ST_IDLE;
              end
            end else if (!status.stuff_due) begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        ST_FLAG_CLOSE: begin
          if (status.out_free) begin
            if (done) begin
              cnt      <= '0;
              in_frame <= 1'b0;
              state    <= ST_IDLE;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/manchester_stuffed_frame_tx.sv */
// top level of the manchester stuffed frame transmitter
//
//  channel   dir  handshake      payload
//  bytes     in   valid/ready    data_byte[7:0], last_byte
//  cells     out  valid/ready    first_half_high, second_half_high,
//                                cell_kind[2:0], run_end, frame_end
//  seed_*    in   write enable   seed_data[15:0] (crc seed, reset 0xffff)
//
// one bit cell per cycle from the controller into the output register unless
// the cells channel stalls; a byte is accepted in idle, then 8 to 10 payload
// cells go out; a frame's first byte adds 24 cells of preamble and flag, the
// last byte 16 to 20 check cells and 8 flag cells; bytes are handled one at a time
// a stalled cells channel freezes the sequencer with the cell held in place
// rst is synchronous: idle, no frame open, seed back to 0xffff
module manchester_stuffed_frame_tx (
  input  logic        clk,
  input  logic        rst,
  mstx_byte_if.sink   bytes,
  mstx_cell_if.source cells,
  input  logic        seed_we,
  input  logic [15:0] seed_data
);

  mstx_pkg::dp_cmd_t    cmd;
  mstx_pkg::dp_status_t status;

  // phase sequencer
  mstx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (bytes.valid),
    .in_ready  (bytes.ready),
    .last_byte (bytes.last_byte),
    .status    (status),
    .cmd       (cmd)
  );

  // shifter, crc and output register
  mstx_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .data_byte        (bytes.data_byte),
    .seed_we          (seed_we),
    .seed_data        (seed_data),
    .out_valid        (cells.valid),
    .out_ready        (cells.ready),
    .first_half_high  (cells.first_half_high),
    .second_half_high (cells.second_half_high),
    .cell_kind        (cells.cell_kind),
    .run_end          (cells.run_end),
    .frame_end        (cells.frame_end)
  );

  // no cell is generated while a new word can be taken
  a_idle_no_emit: assert property (@(posedge clk) disable iff (rst)
    bytes.ready |-> !cmd.emit)
    else $error("cell emitted while input ready");

  // closing flag end always ends the run
  a_frame_end_run_end: assert property (@(posedge clk) disable iff (rst)
    cells.valid && cells.frame_end |-> cells.run_end)
    else $error("frame end without run end");

  // a stuffed cell is always a zero
  a_stuff_zero: assert property (@(posedge clk) disable iff (rst)
    cells.valid && cells.cell_kind == mstx_pkg::KIND_STUFF |->
      cells.first_half_high && !cells.second_half_high)
    else $error("stuffed cell is not a zero");

  // stuffing never lets six ones pass
  a_stuff_taken: assert property (@(posedge clk) disable iff (rst)
    status.stuff_due && cmd.emit |-> cmd.kind == mstx_pkg::KIND_STUFF)
    else $error("stuff cell skipped");

endmodule
